// ===== src/ssp_pkg.sv =====
// shared constants, types and helpers for the shortest path block
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int MAX_EDGES    = 256;
   localparam int WEIGHT_BITS  = 16;

   localparam int OP_W       = 2;
   localparam int VID_W      = 5;
   localparam int WIN_W      = 16;
   localparam int VC_W       = 6;
   localparam int DIST_W     = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam int VC_RESET   = 32;

   localparam int VERTEX_W = $clog2(MAX_VERTICES);
   localparam int VCNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int EDGE_AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECNT_W   = $clog2(MAX_EDGES + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_VERTEX = 1'd1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 2'd0,
      OP_RUN   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACK,
      ST_INIT,
      ST_PLAN,
      ST_EDGE_RD,
      ST_DIST_RD,
      ST_ADD,
      ST_UPDATE,
      ST_EMIT_RD,
      ST_EMIT_WR
   } state_type;

   typedef struct packed {
      logic latch;
      logic ack;
      logic init;
      logic check_start;
      logic pass_next;
      logic edge_next;
      logic edge_rd;
      logic dist_rd;
      logic add;
      logic update;
      logic emit_rd;
      logic emit_wr;
      logic vertex_next;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic src_ok;
      logic edges_none;
      logic nv_one;
      logic improve;
      logic check_mode;
      logic edge_last;
      logic pass_last;
      logic vertex_last;
   } status_type;

   typedef struct packed {
      logic [VID_W-1:0]              origin;
      logic [VID_W-1:0]              target;
      logic signed [WEIGHT_BITS-1:0] weight;
   } edge_type;

   function automatic logic signed [WEIGHT_BITS-1:0] to_weight(
      input logic signed [WIN_W-1:0] raw);
      logic signed [31:0] ext;
      ext = 32'(raw);
      return ext[WEIGHT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/single_source_shortest_path.sv =====
// top level of the single source shortest path block
// Usage: load directed weighted edges with add requests (op 0), then a run
// request (op 1) computes shortest distances from source_vertex over the first
// vertex_count vertices; a clear request (op 2) empties the edge store.
// Both channels use valid/stall; a request is taken when req_valid is high and
// req_stall is low, a result when rsp_valid is high and rsp_stall is low.
// Add, clear and unused requests return one result with last set once the
// output register is free; store_full marks an add dropped on a full store.
// A run returns one result per vertex, vertex 0 first, last set on the final.
// Each edge relax steps through the edge memory read, the distance memory
// read, the saturating add and the compare/write.
// One request is worked at a time; req_stall stays high until its results are
// placed in the output register, which holds a result while rsp_stall is high.
// Reset (synchronous) empties the edge store, clears rsp_valid and sets
// vertex_count to 32 and source_vertex to 0. Configuration is written through
// csr_write/csr_index/csr_wdata, by the user only while idle (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module single_source_shortest_path (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [ssp_pkg::OP_W-1:0]             req_op,
   input  wire logic [ssp_pkg::VID_W-1:0]            req_edge_origin,
   input  wire logic [ssp_pkg::VID_W-1:0]            req_edge_target,
   input  wire logic signed [ssp_pkg::WIN_W-1:0]     req_edge_weight,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [ssp_pkg::VID_W-1:0]                 rsp_vertex,
   output logic signed [ssp_pkg::DIST_W-1:0]         rsp_distance,
   output logic                                      rsp_reached,
   output logic                                      rsp_negative_cycle,
   output logic                                      rsp_store_full,
   output logic                                      rsp_last,
   input  wire logic                                 csr_write,
   input  wire logic [ssp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [ssp_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   ssp_pkg::cmd_type    cmd;
   ssp_pkg::status_type status;

   ssp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd)
   );

   ssp_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_edge_origin    (req_edge_origin),
      .req_edge_target    (req_edge_target),
      .req_edge_weight    (req_edge_weight),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_vertex         (rsp_vertex),
      .rsp_distance       (rsp_distance),
      .rsp_reached        (rsp_reached),
      .rsp_negative_cycle (rsp_negative_cycle),
      .rsp_store_full     (rsp_store_full),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

// ===== src/ssp_ctrl.sv =====
// controller state machine sequencing loads, relax passes and result emission
`timescale 1ns / 1ps
`default_nettype none

module ssp_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [ssp_pkg::OP_W-1:0] req_op,
   input  wire ssp_pkg::status_type      status,
   output ssp_pkg::cmd_type              cmd
);

   ssp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ssp_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               if (ssp_pkg::op_type'(req_op) == ssp_pkg::OP_RUN) begin
                  state_in = ssp_pkg::ST_INIT;
               end else begin
                  state_in = ssp_pkg::ST_ACK;
               end
            end
         end
         ssp_pkg::ST_ACK: begin
            if (status.out_free) begin
               cmd.ack  = 1'b1;
               state_in = ssp_pkg::ST_IDLE;
            end
         end
         ssp_pkg::ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ssp_pkg::ST_PLAN;
         end
         ssp_pkg::ST_PLAN: begin
            if (!status.src_ok || status.edges_none) begin
               state_in = ssp_pkg::ST_EMIT_RD;
            end else begin
               cmd.check_start = status.nv_one;
               state_in        = ssp_pkg::ST_EDGE_RD;
            end
         end
         ssp_pkg::ST_EDGE_RD: begin
            cmd.edge_rd = 1'b1;
            state_in    = ssp_pkg::ST_DIST_RD;
         end
         ssp_pkg::ST_DIST_RD: begin
            cmd.dist_rd = 1'b1;
            state_in    = ssp_pkg::ST_ADD;
         end
         ssp_pkg::ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ssp_pkg::ST_UPDATE;
         end
         ssp_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.check_mode && status.improve) begin
               state_in = ssp_pkg::ST_EMIT_RD;
            end else if (!status.edge_last) begin
               cmd.edge_next = 1'b1;
               state_in      = ssp_pkg::ST_EDGE_RD;
            end else if (status.check_mode) begin
               state_in = ssp_pkg::ST_EMIT_RD;
            end else if (status.pass_last) begin
               cmd.check_start = 1'b1;
               state_in        = ssp_pkg::ST_EDGE_RD;
            end else begin
               cmd.pass_next = 1'b1;
               state_in      = ssp_pkg::ST_EDGE_RD;
            end
         end
         ssp_pkg::ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ssp_pkg::ST_EMIT_WR;
         end
         ssp_pkg::ST_EMIT_WR: begin
            if (status.out_free) begin
               cmd.emit_wr = 1'b1;
               if (status.vertex_last) begin
                  state_in = ssp_pkg::ST_IDLE;
               end else begin
                  cmd.vertex_next = 1'b1;
                  state_in        = ssp_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ssp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/ssp_datapath.sv =====
// datapath: config registers, edge store, distance memory, relax unit, result register
`timescale 1ns / 1ps
`default_nettype none

module ssp_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ssp_pkg::cmd_type                     cmd,
   output ssp_pkg::status_type                       status,
   input  wire logic [ssp_pkg::OP_W-1:0]             req_op,
   input  wire logic [ssp_pkg::VID_W-1:0]            req_edge_origin,
   input  wire logic [ssp_pkg::VID_W-1:0]            req_edge_target,
   input  wire logic signed [ssp_pkg::WIN_W-1:0]     req_edge_weight,
   input  wire logic                                 csr_write,
   input  wire logic [ssp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [ssp_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [ssp_pkg::VID_W-1:0]                 rsp_vertex,
   output logic signed [ssp_pkg::DIST_W-1:0]         rsp_distance,
   output logic                                      rsp_reached,
   output logic                                      rsp_negative_cycle,
   output logic                                      rsp_store_full,
   output logic                                      rsp_last
);

   localparam logic signed [ssp_pkg::DIST_W-1:0] DIST_MAX =
      {1'b0, {(ssp_pkg::DIST_W-1){1'b1}}};
   localparam logic signed [ssp_pkg::DIST_W-1:0] DIST_MIN =
      {1'b1, {(ssp_pkg::DIST_W-1){1'b0}}};

   // configuration
   logic [ssp_pkg::VC_W-1:0]  vertex_count_ff;
   logic [ssp_pkg::VID_W-1:0] source_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= ssp_pkg::VC_W'(ssp_pkg::VC_RESET);
         source_ff       <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            ssp_pkg::CSR_VERTEX_COUNT:  vertex_count_ff <= csr_wdata[ssp_pkg::VC_W-1:0];
            ssp_pkg::CSR_SOURCE_VERTEX: source_ff       <= csr_wdata[ssp_pkg::VID_W-1:0];
            default: ;
         endcase
      end
   end

   // latched request
   ssp_pkg::op_type                        op_ff;
   logic [ssp_pkg::VID_W-1:0]              origin_ff;
   logic [ssp_pkg::VID_W-1:0]              target_ff;
   logic signed [ssp_pkg::WEIGHT_BITS-1:0] weight_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff     <= ssp_pkg::op_type'(req_op);
         origin_ff <= req_edge_origin;
         target_ff <= req_edge_target;
         weight_ff <= ssp_pkg::to_weight(req_edge_weight);
      end
   end

   // edge store
   ssp_pkg::edge_type         edge_mem [ssp_pkg::MAX_EDGES];
   ssp_pkg::edge_type         edge_rd_ff;
   logic [ssp_pkg::ECNT_W-1:0] edge_total_ff;
   logic [ssp_pkg::ECNT_W-1:0] edge_idx_ff;
   logic                       store_full;
   logic                       do_add;

   assign store_full = (edge_total_ff == ssp_pkg::ECNT_W'(ssp_pkg::MAX_EDGES));
   assign do_add     = cmd.ack && (op_ff == ssp_pkg::OP_ADD) && !store_full;

   always_ff @(posedge clock) begin
      if (do_add) begin
         edge_mem[edge_total_ff[ssp_pkg::EDGE_AW-1:0]] <= '{origin_ff, target_ff, weight_ff};
      end
      if (cmd.edge_rd) begin
         edge_rd_ff <= edge_mem[edge_idx_ff[ssp_pkg::EDGE_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_total_ff <= '0;
      end else if (do_add) begin
         edge_total_ff <= ssp_pkg::ECNT_W'(edge_total_ff + 1'b1);
      end else if (cmd.ack && (op_ff == ssp_pkg::OP_CLEAR)) begin
         edge_total_ff <= '0;
      end
   end

   // run bookkeeping
   logic [ssp_pkg::VCNT_W-1:0]       nv_in;
   logic                             src_ok_in;
   logic [ssp_pkg::VCNT_W-1:0]       nv_ff;
   logic                             src_ok_ff;
   logic                             check_ff;
   logic                             cycle_ff;
   logic [ssp_pkg::VCNT_W-1:0]       pass_ff;
   logic [ssp_pkg::VCNT_W-1:0]       vtx_ff;
   logic [ssp_pkg::MAX_VERTICES-1:0] reached_ff;
   logic [ssp_pkg::VERTEX_W-1:0]     src_addr;
   logic [ssp_pkg::VERTEX_W-1:0]     org_addr;
   logic [ssp_pkg::VERTEX_W-1:0]     tgt_addr;
   logic [ssp_pkg::VERTEX_W-1:0]     vtx_addr;
   logic                             improve;

   always_comb begin
      if (vertex_count_ff == '0) begin
         nv_in = ssp_pkg::VCNT_W'(1);
      end else if (int'(vertex_count_ff) > ssp_pkg::MAX_VERTICES) begin
         nv_in = ssp_pkg::VCNT_W'(ssp_pkg::MAX_VERTICES);
      end else begin
         nv_in = ssp_pkg::VCNT_W'(vertex_count_ff);
      end
      src_ok_in = (int'(source_ff) < int'(nv_in));
   end

   assign src_addr = ssp_pkg::VERTEX_W'(source_ff);
   assign org_addr = ssp_pkg::VERTEX_W'(edge_rd_ff.origin);
   assign tgt_addr = ssp_pkg::VERTEX_W'(edge_rd_ff.target);
   assign vtx_addr = vtx_ff[ssp_pkg::VERTEX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         nv_ff     <= nv_in;
         src_ok_ff <= src_ok_in;
         check_ff  <= 1'b0;
         pass_ff   <= ssp_pkg::VCNT_W'(1);
         vtx_ff    <= '0;
         edge_idx_ff <= '0;
      end else begin
         if (cmd.check_start) begin
            check_ff    <= 1'b1;
            edge_idx_ff <= '0;
         end else if (cmd.pass_next) begin
            pass_ff     <= ssp_pkg::VCNT_W'(pass_ff + 1'b1);
            edge_idx_ff <= '0;
         end else if (cmd.edge_next) begin
            edge_idx_ff <= ssp_pkg::ECNT_W'(edge_idx_ff + 1'b1);
         end
         if (cmd.vertex_next) begin
            vtx_ff <= ssp_pkg::VCNT_W'(vtx_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reached_ff <= '0;
         cycle_ff   <= 1'b0;
      end else if (cmd.init) begin
         reached_ff <= '0;
         cycle_ff   <= 1'b0;
         if (src_ok_in) begin
            reached_ff[src_addr] <= 1'b1;
         end
      end else if (cmd.update && improve) begin
         if (check_ff) begin
            cycle_ff <= 1'b1;
         end else begin
            reached_ff[tgt_addr] <= 1'b1;
         end
      end
   end

   // distance memory, one write and two registered reads
   logic signed [ssp_pkg::DIST_W-1:0] dist_mem [ssp_pkg::MAX_VERTICES];
   logic signed [ssp_pkg::DIST_W-1:0] dist_a_ff;
   logic signed [ssp_pkg::DIST_W-1:0] dist_b_ff;
   logic signed [ssp_pkg::DIST_W-1:0] cand_ff;
   logic                              dist_we;
   logic [ssp_pkg::VERTEX_W-1:0]      dist_wa;
   logic signed [ssp_pkg::DIST_W-1:0] dist_wd;

   assign dist_we = (cmd.init && src_ok_in) || (cmd.update && !check_ff && improve);
   assign dist_wa = cmd.init ? src_addr : tgt_addr;
   assign dist_wd = cmd.init ? '0 : cand_ff;

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_wa] <= dist_wd;
      end
      if (cmd.dist_rd) begin
         dist_a_ff <= dist_mem[org_addr];
         dist_b_ff <= dist_mem[tgt_addr];
      end else if (cmd.emit_rd) begin
         dist_a_ff <= dist_mem[vtx_addr];
      end
   end

   // relax: saturating add, then compare
   logic signed [ssp_pkg::DIST_W:0] sum;
   logic                            in_range_ff;
   logic                            reached_o_ff;
   logic                            reached_t_ff;

   assign sum = (ssp_pkg::DIST_W+1)'(dist_a_ff) + (ssp_pkg::DIST_W+1)'(edge_rd_ff.weight);

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         if (sum[ssp_pkg::DIST_W] != sum[ssp_pkg::DIST_W-1]) begin
            cand_ff <= sum[ssp_pkg::DIST_W] ? DIST_MIN : DIST_MAX;
         end else begin
            cand_ff <= sum[ssp_pkg::DIST_W-1:0];
         end
         in_range_ff  <= (int'(edge_rd_ff.origin) < int'(nv_ff)) &&
                         (int'(edge_rd_ff.target) < int'(nv_ff));
         reached_o_ff <= reached_ff[org_addr];
         reached_t_ff <= reached_ff[tgt_addr];
      end
   end

   assign improve = in_range_ff && reached_o_ff && (!reached_t_ff || (cand_ff < dist_b_ff));

   // result register
   logic                              rsp_valid_ff;
   logic [ssp_pkg::VID_W-1:0]         rsp_vertex_ff;
   logic signed [ssp_pkg::DIST_W-1:0] rsp_distance_ff;
   logic                              rsp_reached_ff;
   logic                              rsp_cycle_ff;
   logic                              rsp_full_ff;
   logic                              rsp_last_ff;
   logic                              reached_v;
   logic                              vertex_last;

   assign reached_v   = reached_ff[vtx_addr];
   assign vertex_last = (ssp_pkg::VCNT_W'(vtx_ff + 1'b1) == nv_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.ack || cmd.emit_wr) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ack) begin
         rsp_vertex_ff   <= '0;
         rsp_distance_ff <= '0;
         rsp_reached_ff  <= 1'b0;
         rsp_cycle_ff    <= 1'b0;
         rsp_full_ff     <= (op_ff == ssp_pkg::OP_ADD) && store_full;
         rsp_last_ff     <= 1'b1;
      end else if (cmd.emit_wr) begin
         rsp_vertex_ff   <= ssp_pkg::VID_W'(vtx_ff);
         rsp_distance_ff <= reached_v ? dist_a_ff : '0;
         rsp_reached_ff  <= reached_v;
         rsp_cycle_ff    <= cycle_ff;
         rsp_full_ff     <= 1'b0;
         rsp_last_ff     <= vertex_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_vertex         = rsp_vertex_ff;
   assign rsp_distance       = rsp_distance_ff;
   assign rsp_reached        = rsp_reached_ff;
   assign rsp_negative_cycle = rsp_cycle_ff;
   assign rsp_store_full     = rsp_full_ff;
   assign rsp_last           = rsp_last_ff;

   always_comb begin
      status.out_free    = !rsp_valid_ff || !rsp_stall;
      status.src_ok      = src_ok_ff;
      status.edges_none  = (edge_total_ff == '0);
      status.nv_one      = (nv_ff == ssp_pkg::VCNT_W'(1));
      status.improve     = improve;
      status.check_mode  = check_ff;
      status.edge_last   = (ssp_pkg::ECNT_W'(edge_idx_ff + 1'b1) == edge_total_ff);
      status.pass_last   = (ssp_pkg::VCNT_W'(pass_ff + 1'b1) == nv_ff);
      status.vertex_last = vertex_last;
   end

endmodule

`default_nettype wire

// ===== src/ssp_checker.sv =====
// port level checks for the shortest path block and their bind
`timescale 1ns / 1ps
`default_nettype none

module ssp_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [ssp_pkg::VID_W-1:0]        rsp_vertex,
   input wire logic signed [ssp_pkg::DIST_W-1:0] rsp_distance,
   input wire logic                             rsp_reached,
   input wire logic                             rsp_negative_cycle,
   input wire logic                             rsp_store_full,
   input wire logic                             rsp_last
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_vertex) &&
      $stable(rsp_distance) && $stable(rsp_reached) && $stable(rsp_last))
      else $error("stalled result changed");

   a_unreached_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reached |-> rsp_distance == '0)
      else $error("unreached vertex with nonzero distance");

   a_full_is_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_full |-> rsp_last && !rsp_reached && !rsp_negative_cycle)
      else $error("store full flag outside an add ack");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one still busy");

endmodule

bind single_source_shortest_path ssp_checker u_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking testbench for the single source shortest path block
`timescale 1ns / 1ps

typedef struct packed {
   logic [4:0]         vertex;
   logic signed [31:0] distance;
   logic               reached;
   logic               negative_cycle;
   logic               store_full;
   logic               last;
} ssp_result_type;

class ssp_scoreboard;
   logic [4:0]         edge_from [ssp_pkg::MAX_EDGES];
   logic [4:0]         edge_to [ssp_pkg::MAX_EDGES];
   logic signed [15:0] edge_wt [ssp_pkg::MAX_EDGES];
   int                 edge_count;
   logic [5:0]         vcount;
   logic [4:0]         source;
   logic signed [31:0] dist_val [ssp_pkg::MAX_VERTICES];
   bit                 reach [ssp_pkg::MAX_VERTICES];
   ssp_result_type     pending [$];
   int                 errors;

   function new();
      edge_count = 0;
      vcount = 6'd32;
      source = 5'd0;
      errors = 0;
   endfunction

   function void set_register(logic [ssp_pkg::CSR_IDX_W-1:0] idx, logic [5:0] value);
      if (idx == ssp_pkg::CSR_VERTEX_COUNT) begin
         vcount = value;
      end else begin
         source = value[4:0];
      end
   endfunction

   function void push_ack(bit dropped);
      ssp_result_type r;
      r = '0;
      r.store_full = dropped;
      r.last = 1'b1;
      pending = {pending, r};
   endfunction

   function logic signed [31:0] sat_sum(logic signed [31:0] d, logic signed [15:0] w);
      longint s;
      s = longint'(d) + longint'(w);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s[31:0];
   endfunction

   function bit relax(int e, int nv, bit apply);
      int o;
      int t;
      logic signed [31:0] cand;
      o = edge_from[e];
      t = edge_to[e];
      if (o >= nv || t >= nv || !reach[o]) return 1'b0;
      cand = sat_sum(dist_val[o], edge_wt[e]);
      if (reach[t] && cand >= dist_val[t]) return 1'b0;
      if (apply) begin
         dist_val[t] = cand;
         reach[t] = 1'b1;
      end
      return 1'b1;
   endfunction

   function void predict_run();
      int nv;
      bit cycle;
      ssp_result_type r;
      nv = (vcount == 0) ? 1 : ((vcount > ssp_pkg::MAX_VERTICES) ? ssp_pkg::MAX_VERTICES
                                                                  : int'(vcount));
      for (int v = 0; v < ssp_pkg::MAX_VERTICES; v++) begin
         dist_val[v] = '0;
         reach[v] = 1'b0;
      end
      cycle = 1'b0;
      if (source < nv) begin
         reach[source] = 1'b1;
         for (int p = 1; p < nv; p++) begin
            for (int e = 0; e < edge_count; e++) void'(relax(e, nv, 1'b1));
         end
         for (int e = 0; e < edge_count; e++) begin
            if (relax(e, nv, 1'b0)) begin
               cycle = 1'b1;
               break;
            end
         end
      end
      for (int v = 0; v < nv; v++) begin
         r = '0;
         r.vertex = 5'(v);
         r.distance = reach[v] ? dist_val[v] : 32'sd0;
         r.reached = reach[v];
         r.negative_cycle = cycle;
         r.last = (v == nv - 1);
         pending = {pending, r};
      end
   endfunction

   function void note_request(ssp_pkg::op_type op, logic [4:0] o, logic [4:0] t,
                              logic signed [15:0] w);
      case (op)
         ssp_pkg::OP_ADD: begin
            if (edge_count < ssp_pkg::MAX_EDGES) begin
               edge_from[edge_count] = o;
               edge_to[edge_count] = t;
               edge_wt[edge_count] = w;
               edge_count++;
               push_ack(1'b0);
            end else begin
               push_ack(1'b1);
            end
         end
         ssp_pkg::OP_RUN: predict_run();
         ssp_pkg::OP_CLEAR: begin
            edge_count = 0;
            push_ack(1'b0);
         end
         default: push_ack(1'b0);
      endcase
   endfunction

   task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_result(ssp_result_type got);
      ssp_result_type want;
      if (pending.size() == 0) begin
         report_mismatch($sformatf("unexpected result vertex %0d distance %0d",
                                   got.vertex, got.distance));
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         report_mismatch($sformatf(
            "got v%0d d%0d r%b nc%b sf%b l%b, want v%0d d%0d r%b nc%b sf%b l%b",
            got.vertex, got.distance, got.reached, got.negative_cycle,
            got.store_full, got.last, want.vertex, want.distance, want.reached,
            want.negative_cycle, want.store_full, want.last));
      end
   endtask
endclass

module tb_top;

   localparam int QUIET_LIMIT = 150000;
   localparam int HOLD_CYCLES = 400;

   logic                                     clock;
   logic                                     reset = 1'b1;
   logic                                     req_valid = 1'b0;
   logic                                     req_stall;
   logic [ssp_pkg::OP_W-1:0]                 req_op = '0;
   logic [ssp_pkg::VID_W-1:0]                req_edge_origin = '0;
   logic [ssp_pkg::VID_W-1:0]                req_edge_target = '0;
   logic signed [ssp_pkg::WIN_W-1:0]         req_edge_weight = '0;
   logic                                     rsp_valid;
   logic                                     rsp_stall = 1'b0;
   logic [ssp_pkg::VID_W-1:0]                rsp_vertex;
   logic signed [ssp_pkg::DIST_W-1:0]        rsp_distance;
   logic                                     rsp_reached;
   logic                                     rsp_negative_cycle;
   logic                                     rsp_store_full;
   logic                                     rsp_last;
   logic                                     csr_write = 1'b0;
   logic [ssp_pkg::CSR_IDX_W-1:0]            csr_index = '0;
   logic [ssp_pkg::CSR_DATA_W-1:0]           csr_wdata = '0;

   logic quiet_phase = 1'b0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   idle_cycles = 0;
   int   sent_items = 0;

   ssp_scoreboard sb;

   single_source_shortest_path u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_edge_origin    (req_edge_origin),
      .req_edge_target    (req_edge_target),
      .req_edge_weight    (req_edge_weight),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_vertex         (rsp_vertex),
      .rsp_distance       (rsp_distance),
      .rsp_reached        (rsp_reached),
      .rsp_negative_cycle (rsp_negative_cycle),
      .rsp_store_full     (rsp_store_full),
      .rsp_last           (rsp_last),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: check, random stall, long hold-off on request
   always @(posedge clock) begin : rx
      ssp_result_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_vertex, rsp_distance, rsp_reached, rsp_negative_cycle,
                 rsp_store_full, rsp_last};
         sb.check_result(seen);
      end
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet_phase && ($urandom_range(99) < 13);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= QUIET_LIMIT) begin
         $display("FAIL single_source_shortest_path");
         $finish;
      end
   end

   task automatic send_request(ssp_pkg::op_type op, logic [4:0] o, logic [4:0] t,
                               logic signed [15:0] w);
      while (!quiet_phase && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_edge_origin <= o;
      req_edge_target <= t;
      req_edge_weight <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, o, t, w);
      sent_items++;
   endtask

   task automatic send_other(ssp_pkg::op_type op);
      send_request(op, 5'($urandom), 5'($urandom), 16'($urandom));
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [ssp_pkg::CSR_IDX_W-1:0] idx, logic [5:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      sb.set_register(idx, value);
   endtask

   task automatic configure(logic [5:0] vc, logic [5:0] src);
      wait_drain();
      write_reg(ssp_pkg::CSR_VERTEX_COUNT, vc);
      write_reg(ssp_pkg::CSR_SOURCE_VERTEX, src);
   endtask

   function automatic logic [4:0] pick_vertex(int nv);
      if ($urandom_range(99) < 90) return 5'($urandom_range(0, nv - 1));
      return 5'($urandom_range(0, 31));
   endfunction

   function automatic logic signed [15:0] pick_weight();
      case ($urandom_range(0, 3))
         0: return 16'($signed($urandom_range(0, 40)) - 20);
         1: return 16'($urandom);
         2: return 16'($urandom_range(0, 50));
         default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      endcase
   endfunction

   task automatic random_phase(bit hold_off);
      int vc;
      int nv;
      int src;
      int adds;
      case ($urandom_range(0, 9))
         0: vc = 0;
         1: vc = 1;
         2: vc = 32;
         3: vc = $urandom_range(33, 63);
         default: vc = $urandom_range(2, 8);
      endcase
      nv = (vc == 0) ? 1 : ((vc > 32) ? 32 : vc);
      if ($urandom_range(99) < 85) begin
         src = $urandom_range(0, nv - 1);
      end else begin
         src = $urandom_range(0, 31);
      end
      configure(6'(vc), {1'($urandom_range(0, 1)), 5'(src)});
      if (nv > 8 || sb.edge_count > 48 || $urandom_range(99) < 50) begin
         send_other(ssp_pkg::OP_CLEAR);
      end
      if (hold_off) hold_toggle <= ~hold_toggle;
      adds = (nv > 8) ? $urandom_range(1, 6) : $urandom_range(2, 14);
      repeat (adds) begin
         if ($urandom_range(99) < 8) send_other(ssp_pkg::OP_NONE);
         send_request(ssp_pkg::OP_ADD, pick_vertex(nv), pick_vertex(nv), pick_weight());
      end
      send_other(ssp_pkg::OP_RUN);
   endtask

   initial begin : stimulus
      int phase_no;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty store at reset settings, unused op, clear
      send_other(ssp_pkg::OP_RUN);
      send_request(ssp_pkg::OP_NONE, 5'h1f, 5'h1f, 16'shffff);
      send_other(ssp_pkg::OP_CLEAR);

      // chain with extreme weights and out of range edge ends
      configure(6'd4, 6'd0);
      send_request(ssp_pkg::OP_ADD, 5'd0, 5'd1, 16'sh7fff);
      send_request(ssp_pkg::OP_ADD, 5'd1, 5'd2, 16'sh7fff);
      send_request(ssp_pkg::OP_ADD, 5'd2, 5'd3, 16'sh8000);
      send_request(ssp_pkg::OP_ADD, 5'd3, 5'd31, -16'sd1);
      send_request(ssp_pkg::OP_ADD, 5'd31, 5'd0, 16'sd5);
      send_other(ssp_pkg::OP_RUN);

      // negative cycle
      send_other(ssp_pkg::OP_CLEAR);
      configure(6'd3, 6'd0);
      send_request(ssp_pkg::OP_ADD, 5'd0, 5'd1, 16'sd3);
      send_request(ssp_pkg::OP_ADD, 5'd1, 5'd2, -16'sd4);
      send_request(ssp_pkg::OP_ADD, 5'd2, 5'd1, 16'sd1);
      send_other(ssp_pkg::OP_RUN);

      // source out of range, zero count, saturated count
      configure(6'd3, 6'd5);
      send_other(ssp_pkg::OP_RUN);
      configure(6'd0, 6'h20);
      send_other(ssp_pkg::OP_RUN);
      configure(6'd63, 6'd31);
      send_other(ssp_pkg::OP_RUN);

      // random phases
      phase_no = 0;
      while (sent_items < 100) begin
         quiet_phase <= (phase_no == 3);
         random_phase(phase_no == 1 || phase_no == 5);
         phase_no++;
      end
      quiet_phase <= 1'b0;

      wait_drain();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("PASS single_source_shortest_path");
      end else begin
         $display("FAIL single_source_shortest_path");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
src/ssp_pkg.sv
src/ssp_ctrl.sv
src/ssp_datapath.sv
src/single_source_shortest_path.sv
src/ssp_checker.sv
bench/tb_top.sv
